// ===== sv/keyboard_scancode_queue_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// keyboard scancode queue decoder: assertion macros
// Concurrent check macros used by the top-level design file.
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_SCANCODE_QUEUE_DECODER_DEFINES_SVH
`define KEYBOARD_SCANCODE_QUEUE_DECODER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define KSQD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define KSQD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define KSQD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define KSQD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== sv/ksqd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksqd_pkg
// Shared constants, types and set-1 translation tables of the scan queue.
// ----------------------------------------------------------------------------
package ksqd_pkg;

   localparam int QUEUE_DEPTH = 16;

   localparam int SCAN_W = 8;
   localparam int CHAR_W = 7;
   localparam int MOD_W  = 7;

   // item kinds
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // modifier make and break codes
   localparam logic [SCAN_W-1:0] SC_LSHIFT_MAKE  = 8'h2A;
   localparam logic [SCAN_W-1:0] SC_LSHIFT_BREAK = 8'hAA;
   localparam logic [SCAN_W-1:0] SC_RSHIFT_MAKE  = 8'h36;
   localparam logic [SCAN_W-1:0] SC_RSHIFT_BREAK = 8'hB6;
   localparam logic [SCAN_W-1:0] SC_LCTRL_MAKE   = 8'h1D;
   localparam logic [SCAN_W-1:0] SC_LCTRL_BREAK  = 8'h9D;
   localparam logic [SCAN_W-1:0] SC_LALT_MAKE    = 8'h38;
   localparam logic [SCAN_W-1:0] SC_LALT_BREAK   = 8'hB8;

   // modifier register bits
   localparam logic [MOD_W-1:0] MOD_LSHIFT = 7'h02;
   localparam logic [MOD_W-1:0] MOD_LCTRL  = 7'h04;
   localparam logic [MOD_W-1:0] MOD_LALT   = 7'h08;
   localparam logic [MOD_W-1:0] MOD_RSHIFT = 7'h40;

   // per-cell control
   typedef struct packed {
      logic push;
      logic pop;
   } cell_ctl_type;

   // decoder control
   typedef struct packed {
      logic pop;
      logic empty_read;
   } dec_ctl_type;

   // unshifted us layout, codes 0x00-0x3f
   function automatic logic [CHAR_W-1:0] plain_char(input logic [5:0] idx);
      logic [CHAR_W-1:0] ch;
      unique case (idx)
         6'd2:    ch = 7'h31;
         6'd3:    ch = 7'h32;
         6'd4:    ch = 7'h33;
         6'd5:    ch = 7'h34;
         6'd6:    ch = 7'h35;
         6'd7:    ch = 7'h36;
         6'd8:    ch = 7'h37;
         6'd9:    ch = 7'h38;
         6'd10:   ch = 7'h39;
         6'd11:   ch = 7'h30;
         6'd12:   ch = 7'h2D;
         6'd13:   ch = 7'h3D;
         6'd14:   ch = 7'h08;
         6'd15:   ch = 7'h09;
         6'd16:   ch = 7'h71;
         6'd17:   ch = 7'h77;
         6'd18:   ch = 7'h65;
         6'd19:   ch = 7'h72;
         6'd20:   ch = 7'h74;
         6'd21:   ch = 7'h79;
         6'd22:   ch = 7'h75;
         6'd23:   ch = 7'h69;
         6'd24:   ch = 7'h6F;
         6'd25:   ch = 7'h70;
         6'd26:   ch = 7'h5B;
         6'd27:   ch = 7'h5D;
         6'd28:   ch = 7'h0A;
         6'd30:   ch = 7'h61;
         6'd31:   ch = 7'h73;
         6'd32:   ch = 7'h64;
         6'd33:   ch = 7'h66;
         6'd34:   ch = 7'h67;
         6'd35:   ch = 7'h68;
         6'd36:   ch = 7'h6A;
         6'd37:   ch = 7'h6B;
         6'd38:   ch = 7'h6C;
         6'd39:   ch = 7'h3B;
         6'd40:   ch = 7'h27;
         6'd41:   ch = 7'h60;
         6'd43:   ch = 7'h5C;
         6'd44:   ch = 7'h7A;
         6'd45:   ch = 7'h78;
         6'd46:   ch = 7'h63;
         6'd47:   ch = 7'h76;
         6'd48:   ch = 7'h62;
         6'd49:   ch = 7'h6E;
         6'd50:   ch = 7'h6D;
         6'd51:   ch = 7'h2C;
         6'd52:   ch = 7'h2E;
         6'd53:   ch = 7'h2F;
         6'd57:   ch = 7'h20;
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

   // shifted us layout, codes 0x00-0x3f
   function automatic logic [CHAR_W-1:0] shift_char(input logic [5:0] idx);
      logic [CHAR_W-1:0] ch;
      unique case (idx)
         6'd2:    ch = 7'h21;
         6'd3:    ch = 7'h40;
         6'd4:    ch = 7'h23;
         6'd5:    ch = 7'h24;
         6'd6:    ch = 7'h25;
         6'd7:    ch = 7'h5E;
         6'd8:    ch = 7'h26;
         6'd9:    ch = 7'h2A;
         6'd10:   ch = 7'h28;
         6'd11:   ch = 7'h29;
         6'd12:   ch = 7'h5F;
         6'd13:   ch = 7'h2B;
         6'd14:   ch = 7'h08;
         6'd15:   ch = 7'h09;
         6'd16:   ch = 7'h51;
         6'd17:   ch = 7'h57;
         6'd18:   ch = 7'h45;
         6'd19:   ch = 7'h52;
         6'd20:   ch = 7'h54;
         6'd21:   ch = 7'h59;
         6'd22:   ch = 7'h55;
         6'd23:   ch = 7'h49;
         6'd24:   ch = 7'h4F;
         6'd25:   ch = 7'h50;
         6'd26:   ch = 7'h7B;
         6'd27:   ch = 7'h7D;
         6'd28:   ch = 7'h0A;
         6'd30:   ch = 7'h41;
         6'd31:   ch = 7'h53;
         6'd32:   ch = 7'h44;
         6'd33:   ch = 7'h46;
         6'd34:   ch = 7'h47;
         6'd35:   ch = 7'h48;
         6'd36:   ch = 7'h4A;
         6'd37:   ch = 7'h4B;
         6'd38:   ch = 7'h4C;
         6'd39:   ch = 7'h3A;
         6'd40:   ch = 7'h22;
         6'd41:   ch = 7'h7E;
         6'd43:   ch = 7'h7C;
         6'd44:   ch = 7'h5A;
         6'd45:   ch = 7'h58;
         6'd46:   ch = 7'h43;
         6'd47:   ch = 7'h56;
         6'd48:   ch = 7'h42;
         6'd49:   ch = 7'h4E;
         6'd50:   ch = 7'h4D;
         6'd51:   ch = 7'h3C;
         6'd52:   ch = 7'h3E;
         6'd53:   ch = 7'h3F;
         6'd57:   ch = 7'h20;
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

endpackage

// ===== sv/ksqd_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksqd_cell
// One queue slot: holds a scan byte and its occupied flag. On a pop it takes
// the contents of its right neighbor; on a push it loads the new byte when it
// is the first free slot of the row.
// ----------------------------------------------------------------------------
module ksqd_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  ksqd_pkg::cell_ctl_type         ctl,
   input  logic [ksqd_pkg::SCAN_W-1:0]    push_data,
   input  logic                           left_valid,
   input  logic                           right_valid,
   input  logic [ksqd_pkg::SCAN_W-1:0]    right_data,
   output logic                           valid,
   output logic [ksqd_pkg::SCAN_W-1:0]    data
);

   logic                        valid_ff;
   logic                        valid_in;
   logic [ksqd_pkg::SCAN_W-1:0] data_ff;
   logic [ksqd_pkg::SCAN_W-1:0] data_in;

   // shift toward the head on pop, fill first free slot on push
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (ctl.pop) begin
         valid_in = right_valid;
         data_in  = right_data;
      end else if (ctl.push && !valid_ff && left_valid) begin
         valid_in = 1'b1;
         data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

// ===== sv/ksqd_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksqd_decode
// Set-1 decoder: tracks the modifier register and translates the popped
// byte to ascii, then registers the response word.
// ----------------------------------------------------------------------------
module ksqd_decode (
   input  logic                           clock,
   input  logic                           reset,
   input  ksqd_pkg::dec_ctl_type          ctl,
   input  logic [ksqd_pkg::SCAN_W-1:0]    code,
   output logic                           rsp_strobe,
   output logic [ksqd_pkg::CHAR_W-1:0]    rsp_character,
   output logic [ksqd_pkg::MOD_W-1:0]     rsp_modifiers,
   output logic                           rsp_queue_empty
);

   logic [ksqd_pkg::MOD_W-1:0]  mod_ff;
   logic [ksqd_pkg::MOD_W-1:0]  mod_in;
   logic [ksqd_pkg::MOD_W-1:0]  mod_next;
   logic [ksqd_pkg::CHAR_W-1:0] char_next;
   logic                        strobe_ff;
   logic                        strobe_in;
   logic [ksqd_pkg::CHAR_W-1:0] char_ff;
   logic [ksqd_pkg::CHAR_W-1:0] char_in;
   logic [ksqd_pkg::MOD_W-1:0]  modout_ff;
   logic [ksqd_pkg::MOD_W-1:0]  modout_in;
   logic                        empty_ff;
   logic                        empty_in;
   logic                        shifted;

   // modifier update and table lookup for the head byte
   always_comb begin
      shifted   = |(mod_ff & (ksqd_pkg::MOD_LSHIFT | ksqd_pkg::MOD_RSHIFT));
      mod_next  = mod_ff;
      char_next = '0;
      unique case (code)
         ksqd_pkg::SC_LSHIFT_MAKE:  mod_next = mod_ff | ksqd_pkg::MOD_LSHIFT;
         ksqd_pkg::SC_LSHIFT_BREAK: mod_next = mod_ff & ~ksqd_pkg::MOD_LSHIFT;
         ksqd_pkg::SC_RSHIFT_MAKE:  mod_next = mod_ff | ksqd_pkg::MOD_RSHIFT;
         ksqd_pkg::SC_RSHIFT_BREAK: mod_next = mod_ff & ~ksqd_pkg::MOD_RSHIFT;
         ksqd_pkg::SC_LCTRL_MAKE:   mod_next = mod_ff | ksqd_pkg::MOD_LCTRL;
         ksqd_pkg::SC_LCTRL_BREAK:  mod_next = mod_ff & ~ksqd_pkg::MOD_LCTRL;
         ksqd_pkg::SC_LALT_MAKE:    mod_next = mod_ff | ksqd_pkg::MOD_LALT;
         ksqd_pkg::SC_LALT_BREAK:   mod_next = mod_ff & ~ksqd_pkg::MOD_LALT;
         default: begin
            // press codes below 0x40 only; release and high codes give none
            if (code[7:6] == 2'b00) begin
               char_next = shifted ? ksqd_pkg::shift_char(code[5:0])
                                   : ksqd_pkg::plain_char(code[5:0]);
            end
         end
      endcase
   end

   // response word
   always_comb begin
      strobe_in = ctl.pop || ctl.empty_read;
      mod_in    = ctl.pop ? mod_next : mod_ff;
      char_in   = ctl.pop ? char_next : '0;
      modout_in = ctl.pop ? mod_next : '0;
      empty_in  = ctl.empty_read;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         mod_ff    <= mod_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff   <= char_in;
      modout_ff <= modout_in;
      empty_ff  <= empty_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_character   = char_ff;
   assign rsp_modifiers   = modout_ff;
   assign rsp_queue_empty = empty_ff;

endmodule

// ===== sv/keyboard_scancode_queue_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_scancode_queue_decoder
// Scan byte queue built as a row of slot cells, with a set-1 to ascii
// decoder on the head slot.
//
//   channel   ports                                    handshake
//   request   req_func, req_scan_byte                  start high, busy low
//   response  rsp_character, rsp_modifiers,            rsp_strobe, one cycle
//             rsp_queue_empty
//
// A word is taken in every cycle; busy stays low.
// A push is registered into the slot row and gives no response.
// A read pops the head slot and decodes it in the same cycle; the response
// is registered and is on the ports for a single cycle.
// The receiver cannot stall; each response is taken when shown.
// Synchronous reset empties the row and clears the modifiers; no sweep needed.
// ----------------------------------------------------------------------------
`include "keyboard_scancode_queue_decoder_defines.svh"

module keyboard_scancode_queue_decoder #(
   parameter int QUEUE_DEPTH = ksqd_pkg::QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_func,
   input  logic [ksqd_pkg::SCAN_W-1:0]    req_scan_byte,
   output logic                           rsp_strobe,
   output logic [ksqd_pkg::CHAR_W-1:0]    rsp_character,
   output logic [ksqd_pkg::MOD_W-1:0]     rsp_modifiers,
   output logic                           rsp_queue_empty
);

   logic                        accept;
   logic                        empty;
   ksqd_pkg::cell_ctl_type      cell_ctl;
   ksqd_pkg::dec_ctl_type       dec_ctl;
   logic                        slot_valid [QUEUE_DEPTH];
   logic [ksqd_pkg::SCAN_W-1:0] slot_data  [QUEUE_DEPTH];

   // request decode
   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign empty  = !slot_valid[0];

   assign cell_ctl.push = accept && (req_func == ksqd_pkg::FUNC_PUSH);
   assign cell_ctl.pop  = accept && (req_func == ksqd_pkg::FUNC_READ) && !empty;

   assign dec_ctl.pop        = cell_ctl.pop;
   assign dec_ctl.empty_read = accept && (req_func == ksqd_pkg::FUNC_READ) && empty;

   // slot row, head at index 0; a push into a full row finds no free slot
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
      logic                        left_valid;
      logic                        right_valid;
      logic [ksqd_pkg::SCAN_W-1:0] right_data;

      if (i == 0) begin : g_head
         assign left_valid = 1'b1;
      end else begin : g_body
         assign left_valid = slot_valid[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_valid = 1'b0;
         assign right_data  = '0;
      end else begin : g_inner
         assign right_valid = slot_valid[i+1];
         assign right_data  = slot_data[i+1];
      end

      ksqd_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (cell_ctl),
         .push_data   (req_scan_byte),
         .left_valid  (left_valid),
         .right_valid (right_valid),
         .right_data  (right_data),
         .valid       (slot_valid[i]),
         .data        (slot_data[i])
      );
   end

   // decoder on the head slot
   ksqd_decode u_decode (
      .clock           (clock),
      .reset           (reset),
      .ctl             (dec_ctl),
      .code            (slot_data[0]),
      .rsp_strobe      (rsp_strobe),
      .rsp_character   (rsp_character),
      .rsp_modifiers   (rsp_modifiers),
      .rsp_queue_empty (rsp_queue_empty)
   );

   // checks
   `KSQD_ASSERT_NXT(a_read_gives_word, clock, reset,
      accept && req_func == ksqd_pkg::FUNC_READ, rsp_strobe, "read gave no response word")
   `KSQD_ASSERT_NXT(a_push_fills, clock, reset,
      cell_ctl.push && empty, !empty, "push into empty queue left it empty")
   `KSQD_ASSERT_IMP(a_empty_word_zero, clock, reset,
      rsp_strobe && rsp_queue_empty, rsp_character == '0 && rsp_modifiers == '0,
      "empty response carries data")
   `KSQD_ASSERT_IMP(a_mod_bits_legal, clock, reset,
      rsp_strobe, (rsp_modifiers & 7'h31) == '0, "undefined modifier bit set")

endmodule

// ===== tb/sv/keyboard_scancode_queue_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_scancode_queue_decoder_tb
// Self-checking bench for the scan byte queue and set-1 decoder. Scan bytes
// are pushed and keystrokes read back with random gaps. A scoreboard keeps its
// own copy of the queue, the pointers and the modifier state. Every response
// word is checked field by field against the oldest predicted keystroke.
// ----------------------------------------------------------------------------
module keyboard_scancode_queue_decoder_tb;

   localparam int CLK_PERIOD   = 20;
   localparam int RESET_CYCLES = 12;
   localparam int WORD_TARGET  = 1550;
   localparam int DRAIN_LIMIT  = 200;

   // unshifted us layout for codes 0x00-0x3f
   localparam logic [ksqd_pkg::CHAR_W-1:0] PLAIN_KEYS [0:63] = '{
      7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
      7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
      7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
      7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
      7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
      7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00,
      7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
   };

   // shifted us layout for codes 0x00-0x3f
   localparam logic [ksqd_pkg::CHAR_W-1:0] SHIFT_KEYS [0:63] = '{
      7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
      7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
      7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
      7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
      7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
      7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00,
      7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
   };

   typedef struct {
      logic [ksqd_pkg::CHAR_W-1:0] character;
      logic [ksqd_pkg::MOD_W-1:0]  modifiers;
      logic                        queue_empty;
   } keystroke_type;

   // queue and decoder predictor with a list of pending keystrokes
   class keystroke_scoreboard;
      logic [ksqd_pkg::SCAN_W-1:0] slots [ksqd_pkg::QUEUE_DEPTH];
      int unsigned                 wr_ptr;
      int unsigned                 rd_ptr;
      logic [ksqd_pkg::MOD_W-1:0]  mod_bits;
      keystroke_type               pending [$];
      int                          errors;
      int                          pushes;
      int                          drops;
      int                          reads;
      int                          empties;
      int                          chars;

      function new();
         for (int i = 0; i < ksqd_pkg::QUEUE_DEPTH; i++) slots[i] = '0;
         wr_ptr   = 0;
         rd_ptr   = 0;
         mod_bits = '0;
         errors   = 0;
         pushes   = 0;
         drops    = 0;
         reads    = 0;
         empties  = 0;
         chars    = 0;
      endfunction

      function int outstanding();
         return pending.size();
      endfunction

      // modifier update and table lookup for one popped byte
      function logic [ksqd_pkg::CHAR_W-1:0] apply_scan_code(
         logic [ksqd_pkg::SCAN_W-1:0] code);
         logic [ksqd_pkg::CHAR_W-1:0] ch;
         ch = '0;
         case (code)
            ksqd_pkg::SC_LSHIFT_MAKE:  mod_bits = mod_bits | ksqd_pkg::MOD_LSHIFT;
            ksqd_pkg::SC_LSHIFT_BREAK: mod_bits = mod_bits & ~ksqd_pkg::MOD_LSHIFT;
            ksqd_pkg::SC_RSHIFT_MAKE:  mod_bits = mod_bits | ksqd_pkg::MOD_RSHIFT;
            ksqd_pkg::SC_RSHIFT_BREAK: mod_bits = mod_bits & ~ksqd_pkg::MOD_RSHIFT;
            ksqd_pkg::SC_LCTRL_MAKE:   mod_bits = mod_bits | ksqd_pkg::MOD_LCTRL;
            ksqd_pkg::SC_LCTRL_BREAK:  mod_bits = mod_bits & ~ksqd_pkg::MOD_LCTRL;
            ksqd_pkg::SC_LALT_MAKE:    mod_bits = mod_bits | ksqd_pkg::MOD_LALT;
            ksqd_pkg::SC_LALT_BREAK:   mod_bits = mod_bits & ~ksqd_pkg::MOD_LALT;
            default: begin
               // only press codes inside the table give a character
               if (code < 8'h40) begin
                  if ((mod_bits & (ksqd_pkg::MOD_LSHIFT | ksqd_pkg::MOD_RSHIFT)) != '0)
                     ch = SHIFT_KEYS[code[5:0]];
                  else
                     ch = PLAIN_KEYS[code[5:0]];
               end
            end
         endcase
         return ch;
      endfunction

      // accepted request word
      function void note_word(logic func, logic [ksqd_pkg::SCAN_W-1:0] code);
         keystroke_type ks;
         int unsigned   fill;
         fill = (wr_ptr + 2 * ksqd_pkg::QUEUE_DEPTH - rd_ptr) % (2 * ksqd_pkg::QUEUE_DEPTH);
         if (func == ksqd_pkg::FUNC_PUSH) begin
            pushes++;
            if (fill < ksqd_pkg::QUEUE_DEPTH) begin
               slots[wr_ptr % ksqd_pkg::QUEUE_DEPTH] = code;
               wr_ptr = (wr_ptr + 1) % (2 * ksqd_pkg::QUEUE_DEPTH);
            end else begin
               drops++;
            end
         end else begin
            reads++;
            if (fill == 0) begin
               empties++;
               ks.character   = '0;
               ks.modifiers   = '0;
               ks.queue_empty = 1'b1;
            end else begin
               ks.character   = apply_scan_code(slots[rd_ptr % ksqd_pkg::QUEUE_DEPTH]);
               rd_ptr         = (rd_ptr + 1) % (2 * ksqd_pkg::QUEUE_DEPTH);
               ks.modifiers   = mod_bits;
               ks.queue_empty = 1'b0;
               if (ks.character != '0) chars++;
            end
            pending.push_back(ks);
         end
      endfunction

      // response word against the oldest pending keystroke
      function void check_result(logic [ksqd_pkg::CHAR_W-1:0] ch,
                                 logic [ksqd_pkg::MOD_W-1:0] mods, logic empty);
         keystroke_type ks;
         if (pending.size() == 0) begin
            $error("unexpected response word: character %h modifiers %h empty %b",
                   ch, mods, empty);
            errors++;
            return;
         end
         ks = pending.pop_front();
         if (ch !== ks.character) begin
            $error("character: expected %h actual %h", ks.character, ch);
            errors++;
         end
         if (mods !== ks.modifiers) begin
            $error("modifiers: expected %h actual %h", ks.modifiers, mods);
            errors++;
         end
         if (empty !== ks.queue_empty) begin
            $error("queue_empty: expected %b actual %b", ks.queue_empty, empty);
            errors++;
         end
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic                        req_func = ksqd_pkg::FUNC_PUSH;
   logic [ksqd_pkg::SCAN_W-1:0] req_scan_byte = '0;
   logic                        rsp_strobe;
   logic [ksqd_pkg::CHAR_W-1:0] rsp_character;
   logic [ksqd_pkg::MOD_W-1:0]  rsp_modifiers;
   logic                        rsp_queue_empty;

   keystroke_scoreboard sb = new();
   int                  words_sent = 0;

   keyboard_scancode_queue_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_scan_byte   (req_scan_byte),
      .rsp_strobe      (rsp_strobe),
      .rsp_character   (rsp_character),
      .rsp_modifiers   (rsp_modifiers),
      .rsp_queue_empty (rsp_queue_empty)
   );

   // clock
   always #(CLK_PERIOD / 2) clock = ~clock;

   // monitor: check the response first, then note the word taken at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) sb.check_result(rsp_character, rsp_modifiers, rsp_queue_empty);
         if (start && !busy) sb.note_word(req_func, req_scan_byte);
      end
   end

   // present one word and hold it until taken
   task automatic send_word(input logic func, input logic [ksqd_pkg::SCAN_W-1:0] code);
      start         <= 1'b1;
      req_func      <= func;
      req_scan_byte <= code;
      do @(posedge clock); while (busy);
      words_sent++;
   endtask

   task automatic idle_for(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // hold the sender off until every pending keystroke has come back
   task automatic drain_responses();
      start <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() > 0) @(posedge clock);
   endtask

   // mostly short gaps, a few long ones
   function automatic int pick_gap(bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(48, 20);
   endfunction

   // typing-like scan byte mix
   function automatic logic [ksqd_pkg::SCAN_W-1:0] pick_code();
      int r;
      r = $urandom_range(99);
      if (r < 25) begin
         case ($urandom_range(7))
            0: return ksqd_pkg::SC_LSHIFT_MAKE;
            1: return ksqd_pkg::SC_LSHIFT_BREAK;
            2: return ksqd_pkg::SC_RSHIFT_MAKE;
            3: return ksqd_pkg::SC_RSHIFT_BREAK;
            4: return ksqd_pkg::SC_LCTRL_MAKE;
            5: return ksqd_pkg::SC_LCTRL_BREAK;
            6: return ksqd_pkg::SC_LALT_MAKE;
            default: return ksqd_pkg::SC_LALT_BREAK;
         endcase
      end
      if (r < 75) return 8'($urandom_range(8'h3F));
      if (r < 85) return 8'($urandom_range(8'h7F, 8'h40));
      return 8'($urandom_range(8'hFF, 8'h80));
   endfunction

   task automatic push_code(input logic [ksqd_pkg::SCAN_W-1:0] code, input bit quiet);
      send_word(ksqd_pkg::FUNC_PUSH, code);
      idle_for(pick_gap(quiet));
   endtask

   task automatic read_key(input bit quiet);
      send_word(ksqd_pkg::FUNC_READ, 8'($urandom_range(255)));
      idle_for(pick_gap(quiet));
   endtask

   // stimulus
   initial begin
      logic [ksqd_pkg::SCAN_W-1:0] directed [];
      int  kind;
      int  n;
      bit  quiet;
      int  wait_cycles;

      directed = '{
         ksqd_pkg::SC_LSHIFT_MAKE, 8'h1E, ksqd_pkg::SC_LSHIFT_BREAK, 8'h1E, 8'h00,
         8'hFF, 8'h7F, ksqd_pkg::SC_RSHIFT_MAKE, 8'h35, ksqd_pkg::SC_RSHIFT_BREAK,
         ksqd_pkg::SC_LCTRL_MAKE, ksqd_pkg::SC_LALT_MAKE, ksqd_pkg::SC_LCTRL_BREAK,
         ksqd_pkg::SC_LALT_BREAK
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty read, modifier make and break, table edges, release
      read_key(1'b0);
      foreach (directed[i]) push_code(directed[i], 1'b0);
      for (int i = 0; i <= directed.size(); i++) read_key(1'b0);
      drain_responses();

      // random bursts
      while (words_sent < WORD_TARGET) begin
         kind  = $urandom_range(99);
         quiet = ($urandom_range(3) == 0);
         if (kind < 60) begin
            // keystroke run: push a few bytes, read them back
            n = $urandom_range(8, 1);
            repeat (n) push_code(pick_code(), quiet);
            repeat (n + (($urandom_range(4) == 0) ? 1 : 0)) read_key(quiet);
         end else if (kind < 75) begin
            // push and read interleaved
            n = $urandom_range(6, 1);
            repeat (n) begin
               push_code(pick_code(), quiet);
               read_key(quiet);
            end
         end else if (kind < 87) begin
            // push near or past the queue depth, then read near or past empty
            n = $urandom_range(ksqd_pkg::QUEUE_DEPTH + 4, ksqd_pkg::QUEUE_DEPTH - 2);
            repeat (n) push_code(pick_code(), quiet);
            n = $urandom_range(ksqd_pkg::QUEUE_DEPTH + 4, ksqd_pkg::QUEUE_DEPTH - 2);
            repeat (n) read_key(quiet);
         end else begin
            // noise: any kind, any byte
            n = $urandom_range(6, 1);
            repeat (n) begin
               send_word(1'($urandom_range(1)), 8'($urandom_range(255)));
               idle_for(pick_gap(quiet));
            end
         end
         if ($urandom_range(9) == 0) drain_responses();
      end

      // wait out the last responses
      start <= 1'b0;
      wait_cycles = 0;
      while (sb.outstanding() > 0 && wait_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (4) @(posedge clock);
      if (sb.outstanding() > 0) begin
         $error("%0d keystrokes never came back", sb.outstanding());
         sb.errors++;
      end

      $display("covered %0d words: %0d pushes (%0d dropped on full), %0d reads",
               words_sent, sb.pushes, sb.drops, sb.reads);
      $display("reads found the queue empty %0d times, %0d decoded characters",
               sb.empties, sb.chars);
      if (sb.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // run limit
   initial begin
      #(10_000_000);
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ksqd_pkg.sv
sv/ksqd_cell.sv
sv/ksqd_decode.sv
sv/keyboard_scancode_queue_decoder.sv
tb/sv/keyboard_scancode_queue_decoder_tb.sv
